// ===== hdl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and datapath operation codes for the odometry core.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POS_WIDTH_DEF    = 48;

  localparam int CNT_W   = 32;   // encoder count width
  localparam int GAIN_W  = 32;   // register width
  localparam int OUT_W   = 48;   // position output width
  localparam int ANG_W   = 32;   // binary angle width
  localparam int STEP_W  = 5;    // atan table index
  localparam int OP_W    = 4;
  localparam int ADDR_W  = 4;

  // CORDIC gain compensation, Q30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  // register indexes
  localparam logic [1:0] REG_LEFT_GAIN    = 2'd0;
  localparam logic [1:0] REG_RIGHT_GAIN   = 2'd1;
  localparam logic [1:0] REG_HEADING_GAIN = 2'd2;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL_L  = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL_R  = 4'd3;
  localparam logic [OP_W-1:0] OP_TR     = 4'd4;
  localparam logic [OP_W-1:0] OP_DIFF   = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL_DL = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL_DH = 4'd7;
  localparam logic [OP_W-1:0] OP_ANG    = 4'd8;
  localparam logic [OP_W-1:0] OP_CINIT  = 4'd9;
  localparam logic [OP_W-1:0] OP_ITER   = 4'd10;
  localparam logic [OP_W-1:0] OP_FIN    = 4'd11;
  localparam logic [OP_W-1:0] OP_MXL    = 4'd12;
  localparam logic [OP_W-1:0] OP_MXH    = 4'd13;
  localparam logic [OP_W-1:0] OP_MYL    = 4'd14;
  localparam logic [OP_W-1:0] OP_MYH    = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] step;
    logic              sum_y;     // form the y sum
    logic              add_y;     // accumulate y
    logic              load_out;  // capture the pose into the output register
  } ddo_cmd_t;

  // atan(2^-i) as binary angle
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

// ===== hdl/ddo_if.sv =====
// ----------------------------------------------------------------------------
// ddo_if
// Valid/ready channels for encoder updates and pose results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddo_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [ddo_pkg::CNT_W-1:0]    left_count;
  logic signed [ddo_pkg::CNT_W-1:0]    right_count;
  modport source (output valid, cmd, left_count, right_count, input ready);
  modport sink   (input valid, cmd, left_count, right_count, output ready);
endinterface

interface ddo_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddo_pkg::OUT_W-1:0]    pos_x;
  logic signed [ddo_pkg::OUT_W-1:0]    pos_y;
  logic signed [ddo_pkg::ANG_W-1:0]    heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

`default_nettype wire

// ===== hdl/ddo_regs.sv =====
// ----------------------------------------------------------------------------
// ddo_regs
// APB configuration registers: wheel gains and heading gain.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ddo_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output logic      [ddo_pkg::GAIN_W-1:0]  left_gain,
  output logic      [ddo_pkg::GAIN_W-1:0]  right_gain,
  output logic      [ddo_pkg::GAIN_W-1:0]  head_gain
);

  logic [31:0] left_r, left_nxt, right_r, right_nxt, head_r, head_nxt;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    head_nxt  = head_r;
    if (wr) begin
      case (idx)
        ddo_pkg::REG_LEFT_GAIN:    left_nxt  = pwdata;
        ddo_pkg::REG_RIGHT_GAIN:   right_nxt = pwdata;
        ddo_pkg::REG_HEADING_GAIN: head_nxt  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ddo_pkg::REG_LEFT_GAIN:    prdata = left_r;
      ddo_pkg::REG_RIGHT_GAIN:   prdata = right_r;
      ddo_pkg::REG_HEADING_GAIN: prdata = head_r;
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
      head_r  <= '0;
    end else begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      head_r  <= head_nxt;
    end
  end

  assign left_gain  = left_r;
  assign right_gain = right_r;
  assign head_gain  = head_r;

endmodule

`default_nettype wire

// ===== hdl/ddo_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: steps the datapath through one update and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_ctrl #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_cmd,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ddo_pkg::ddo_cmd_t      dp_cmd
);

  localparam int CW = $clog2(CORDIC_STEPS + 1);
  localparam int SW = ddo_pkg::STEP_W;
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MUL_L = 5'd1;
  localparam logic [4:0] S_MUL_R = 5'd2;
  localparam logic [4:0] S_TR    = 5'd3;
  localparam logic [4:0] S_DIFF  = 5'd4;
  localparam logic [4:0] S_MDL   = 5'd5;
  localparam logic [4:0] S_MDH   = 5'd6;
  localparam logic [4:0] S_ANG   = 5'd7;
  localparam logic [4:0] S_CINIT = 5'd8;
  localparam logic [4:0] S_ITER  = 5'd9;
  localparam logic [4:0] S_FIN   = 5'd10;
  localparam logic [4:0] S_MXL   = 5'd11;
  localparam logic [4:0] S_MXH   = 5'd12;
  localparam logic [4:0] S_MYL   = 5'd13;
  localparam logic [4:0] S_MYH   = 5'd14;
  localparam logic [4:0] S_SY    = 5'd15;
  localparam logic [4:0] S_AY    = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic          accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    dp_cmd    = '0;
    dp_cmd.op = ddo_pkg::OP_NOP;
    dp_cmd.step = SW'(cnt_r);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          dp_cmd.op = ddo_pkg::OP_LOAD;
          state_nxt = in_cmd ? S_DONE : S_MUL_L;
        end
      end
      S_MUL_L: begin dp_cmd.op = ddo_pkg::OP_MUL_L;  state_nxt = S_MUL_R; end
      S_MUL_R: begin dp_cmd.op = ddo_pkg::OP_MUL_R;  state_nxt = S_TR;    end
      S_TR:    begin dp_cmd.op = ddo_pkg::OP_TR;     state_nxt = S_DIFF;  end
      S_DIFF:  begin dp_cmd.op = ddo_pkg::OP_DIFF;   state_nxt = S_MDL;   end
      S_MDL:   begin dp_cmd.op = ddo_pkg::OP_MUL_DL; state_nxt = S_MDH;   end
      S_MDH:   begin dp_cmd.op = ddo_pkg::OP_MUL_DH; state_nxt = S_ANG;   end
      S_ANG:   begin dp_cmd.op = ddo_pkg::OP_ANG;    state_nxt = S_CINIT; end
      S_CINIT: begin
        dp_cmd.op = ddo_pkg::OP_CINIT;
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        dp_cmd.op = ddo_pkg::OP_ITER;
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == LAST) state_nxt = S_FIN;
      end
      S_FIN:   begin dp_cmd.op = ddo_pkg::OP_FIN;    state_nxt = S_MXL;   end
      S_MXL:   begin dp_cmd.op = ddo_pkg::OP_MXL;    state_nxt = S_MXH;   end
      S_MXH:   begin dp_cmd.op = ddo_pkg::OP_MXH;    state_nxt = S_MYL;   end
      S_MYL:   begin dp_cmd.op = ddo_pkg::OP_MYL;    state_nxt = S_MYH;   end
      S_MYH:   begin dp_cmd.op = ddo_pkg::OP_MYH;    state_nxt = S_SY;    end
      S_SY:    begin dp_cmd.sum_y = 1'b1;            state_nxt = S_AY;    end
      S_AY:    begin dp_cmd.add_y = 1'b1;            state_nxt = S_DONE;  end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          dp_cmd.load_out = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ddo_dp.sv =====
// ----------------------------------------------------------------------------
// ddo_dp
// Datapath: shared 33x33 multiplier, iterative CORDIC, pose accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_dp #(
  parameter int POS_WIDTH = ddo_pkg::POS_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ddo_pkg::ddo_cmd_t                 dp_cmd,
  input  wire logic                              in_cmd,
  input  wire logic [ddo_pkg::CNT_W-1:0]         left_count,
  input  wire logic [ddo_pkg::CNT_W-1:0]         right_count,
  input  wire logic [ddo_pkg::GAIN_W-1:0]        left_gain,
  input  wire logic [ddo_pkg::GAIN_W-1:0]        right_gain,
  input  wire logic [ddo_pkg::GAIN_W-1:0]        head_gain,
  output logic      [ddo_pkg::OUT_W-1:0]         pos_x,
  output logic      [ddo_pkg::OUT_W-1:0]         pos_y,
  output logic      [ddo_pkg::ANG_W-1:0]         heading
);

  // pose state
  logic [31:0]          last_l_r, last_r_r, head_r;
  logic [POS_WIDTH-1:0] acc_x_r, acc_y_r;

  // per-item working registers
  logic [31:0]          dtl_r, dtr_r;
  logic signed [65:0]   prod_r;
  logic signed [55:0]   tl_r, tr_r, dd_r;
  logic [56:0]          diff_r;
  logic [48:0]          plo_r;
  logic [31:0]          da_r, half_r;
  logic signed [33:0]   cx_r, cy_r, cz_r;
  logic                 flip_r;
  logic signed [65:0]   pl_r;
  logic [95:0]          sum_r;
  logic [47:0]          ox_r, oy_r;
  logic [31:0]          oh_r;

  // output view of the accumulators
  logic [47:0]          pos_x_ext, pos_y_ext;

  // multiplier
  logic signed [32:0]   ma, mb;
  logic signed [65:0]   mp;

  always_comb begin
    ma = '0;
    mb = '0;
    case (dp_cmd.op)
      ddo_pkg::OP_MUL_L:  begin ma = {dtl_r[31], dtl_r};  mb = {1'b0, left_gain};  end
      ddo_pkg::OP_MUL_R:  begin ma = {dtr_r[31], dtr_r};  mb = {1'b0, right_gain}; end
      ddo_pkg::OP_MUL_DL: begin ma = {1'b0, diff_r[31:0]}; mb = {1'b0, head_gain}; end
      ddo_pkg::OP_MUL_DH: begin ma = {16'd0, diff_r[48:32]}; mb = {1'b0, head_gain}; end
      ddo_pkg::OP_MXL:    begin ma = {1'b0, dd_r[31:0]};  mb = cx_r[32:0]; end
      ddo_pkg::OP_MXH:    begin ma = {{9{dd_r[55]}}, dd_r[55:32]}; mb = cx_r[32:0]; end
      ddo_pkg::OP_MYL:    begin ma = {1'b0, dd_r[31:0]};  mb = cy_r[32:0]; end
      ddo_pkg::OP_MYH:    begin ma = {{9{dd_r[55]}}, dd_r[55:32]}; mb = cy_r[32:0]; end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  // heading change and half angle from the split product
  logic [48:0] p49;
  assign p49 = plo_r + {prod_r[16:0], 32'd0};

  // CORDIC start angle, rotated by pi outside [-pi/2, pi/2)
  logic [31:0] ang, ang_q, ang_r;
  logic        flip;
  assign ang   = head_r + half_r;
  assign ang_q = ang + 32'h4000_0000;
  assign flip  = ang_q[31];
  assign ang_r = flip ? (ang + 32'h8000_0000) : ang;

  // one CORDIC step
  logic signed [33:0] xs, ys, at, x_it, y_it, z_it;
  assign xs = cx_r >>> dp_cmd.step;
  assign ys = cy_r >>> dp_cmd.step;
  assign at = {2'b00, ddo_pkg::ATAN_TAB[dp_cmd.step]};
  always_comb begin
    if (!cz_r[33]) begin
      x_it = cx_r - ys;
      y_it = cy_r + xs;
      z_it = cz_r - at;
    end else begin
      x_it = cx_r + ys;
      y_it = cy_r - xs;
      z_it = cz_r + at;
    end
  end

  logic [56:0] tsum;
  assign tsum = {tl_r[55], tl_r} + {tr_r[55], tr_r};

  // full product from the low and high partial products
  logic [95:0] part_sum;
  assign part_sum = {{30{pl_r[65]}}, pl_r} + {prod_r[63:0], 32'd0};

  always_ff @(posedge clk) begin
    prod_r <= mp;
    case (dp_cmd.op)
      ddo_pkg::OP_LOAD: begin
        dtl_r <= left_count - last_l_r;
        dtr_r <= right_count - last_r_r;
      end
      ddo_pkg::OP_MUL_R:  tl_r   <= prod_r[63:8];
      ddo_pkg::OP_TR:     tr_r   <= prod_r[63:8];
      ddo_pkg::OP_DIFF: begin
        diff_r <= {tr_r[55], tr_r} - {tl_r[55], tl_r};
        dd_r   <= tsum[56:1];
      end
      ddo_pkg::OP_MUL_DH: plo_r  <= prod_r[48:0];
      ddo_pkg::OP_ANG: begin
        da_r   <= p49[47:16];
        half_r <= p49[48:17];
      end
      ddo_pkg::OP_CINIT: begin
        cx_r   <= ddo_pkg::CORDIC_K;
        cy_r   <= '0;
        cz_r   <= {{2{ang_r[31]}}, ang_r};
        flip_r <= flip;
      end
      ddo_pkg::OP_ITER: begin
        cx_r <= x_it;
        cy_r <= y_it;
        cz_r <= z_it;
      end
      ddo_pkg::OP_FIN: begin
        if (flip_r) begin
          cx_r <= -cx_r;
          cy_r <= -cy_r;
        end
      end
      ddo_pkg::OP_MXH:    pl_r  <= prod_r;
      ddo_pkg::OP_MYL:    sum_r <= part_sum;
      ddo_pkg::OP_MYH:    pl_r  <= prod_r;
      default: ;
    endcase
    if (dp_cmd.sum_y) sum_r <= part_sum;
    if (dp_cmd.load_out) begin
      ox_r <= pos_x_ext;
      oy_r <= pos_y_ext;
      oh_r <= head_r;
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_l_r <= '0;
      last_r_r <= '0;
      head_r   <= '0;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
    end else begin
      if (dp_cmd.op == ddo_pkg::OP_LOAD) begin
        if (in_cmd) begin
          last_l_r <= '0;
          last_r_r <= '0;
          head_r   <= '0;
          acc_x_r  <= '0;
          acc_y_r  <= '0;
        end else begin
          last_l_r <= left_count;
          last_r_r <= right_count;
        end
      end
      if (dp_cmd.op == ddo_pkg::OP_FIN) head_r <= head_r + da_r;
      if (dp_cmd.op == ddo_pkg::OP_MYH) acc_x_r <= acc_x_r + sum_r[POS_WIDTH+29:30];
      if (dp_cmd.add_y)                 acc_y_r <= acc_y_r + sum_r[POS_WIDTH+29:30];
    end
  end

  // output view: low bits of the accumulators, zero-filled when narrower
  generate
    if (POS_WIDTH >= ddo_pkg::OUT_W) begin : g_wide
      assign pos_x_ext = acc_x_r[ddo_pkg::OUT_W-1:0];
      assign pos_y_ext = acc_y_r[ddo_pkg::OUT_W-1:0];
    end else begin : g_narrow
      assign pos_x_ext = {{(ddo_pkg::OUT_W-POS_WIDTH){1'b0}}, acc_x_r};
      assign pos_y_ext = {{(ddo_pkg::OUT_W-POS_WIDTH){1'b0}}, acc_y_r};
    end
  endgenerate

  assign pos_x   = ox_r;
  assign pos_y   = oy_r;
  assign heading = oh_r;

endmodule

`default_nettype wire

// ===== hdl/differential_drive_odometry_core.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Dead-reckoning pose tracker for a two-wheel robot, midpoint integration.
// ----------------------------------------------------------------------------
// Each input transaction carries absolute left/right encoder counts (cmd 0)
// or a pose reset (cmd 1), and produces exactly one result transaction with
// the pose: x and y in 2^-16 mm, heading as a 32-bit binary angle. An update
// is paced by the iterative CORDIC (one micro-rotation per cycle) and by the
// single shared 33x33 multiplier, used eight times per update. One
// transaction is worked on at a time; the result sits in an output register,
// so the next input is taken while an earlier result still waits. Gains are
// written over APB (left gain at 0x0, right at 0x4, heading gain at 0x8); the
// user must write them only while the core is idle, as the block itself does
// not enforce this.
`default_nettype none

module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,  // 8..32
  parameter int POS_WIDTH    = ddo_pkg::POS_WIDTH_DEF      // 32..64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ddo_in_if.sink                           in_chan,
  ddo_out_if.source                        out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ddo_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  logic [31:0]       left_gain, right_gain, head_gain;
  ddo_pkg::ddo_cmd_t dp_cmd;

  // configuration registers
  ddo_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .left_gain  (left_gain),
    .right_gain (right_gain),
    .head_gain  (head_gain)
  );

  // sequencer: handshakes and per-cycle datapath op
  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .dp_cmd    (dp_cmd)
  );

  // arithmetic and pose state
  ddo_dp #(.POS_WIDTH(POS_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .in_cmd      (in_chan.cmd),
    .left_count  (in_chan.left_count),
    .right_count (in_chan.right_count),
    .left_gain   (left_gain),
    .right_gain  (right_gain),
    .head_gain   (head_gain),
    .pos_x       (out_chan.pos_x),
    .pos_y       (out_chan.pos_y),
    .heading     (out_chan.heading)
  );

endmodule

`default_nettype wire
